[hw/rtl/pal_pkg.sv]
`default_nettype none
package pal_pkg;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_REM_HEAD = 3'd3,
    REQ_REM_TAIL = 3'd4,
    REQ_REM_POS  = 3'd5
  } req_kind_t;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INS_REJ = 2'd1;
  localparam logic [1:0] ST_REM_REJ = 2'd2;

  localparam int POS_W   = 9;
  localparam int VAL_W   = 16;
  localparam int COUNT_W = 9;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VAL_W-1:0]   removed_value;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage
`default_nettype wire

[hw/rtl/pal_cell.sv]
`default_nettype none
module pal_cell #(
  parameter int W     = 16,
  parameter int IDX_W = 8,
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire pal_pkg::cell_op_t   op,
  input  wire logic [IDX_W-1:0]    idx,
  input  wire logic [W-1:0]        left_val,
  input  wire logic [W-1:0]        right_val,
  input  wire logic [W-1:0]        new_val,
  output logic [W-1:0]             val
);
  import pal_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [W-1:0] val_r, val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (en) begin
      if (op.ins) begin
        if (MY_IDX > idx) begin
          val_nxt = left_val;
        end else if (MY_IDX == idx) begin
          val_nxt = new_val;
        end
      end else if (op.rem && MY_IDX >= idx) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

[hw/rtl/pal_sel.sv]
`default_nettype none
module pal_sel #(
  parameter int W     = 16,
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [W-1:0]     cells [DEPTH],
  output logic [W-1:0]          pick
);
  import pal_pkg::*;

  localparam int GROUP = 16;
  localparam int LO_W  = $clog2(GROUP);
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int HI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SEL_W = LO_W + HI_W;

  logic [SEL_W-1:0] idx_ext;
  logic [LO_W-1:0]  lo;
  logic [W-1:0]     grp_cells [NGRP][GROUP];
  logic [W-1:0]     grp_r [NGRP];
  logic [HI_W-1:0]  hi_r;

  assign idx_ext = SEL_W'(idx);
  assign lo      = idx_ext[LO_W-1:0];

  // pad the last group with zeros where DEPTH is not a multiple of GROUP
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar k = 0; k < GROUP; k++) begin : g_mem
      if (g * GROUP + k < DEPTH) begin : g_real
        assign grp_cells[g][k] = cells[g * GROUP + k];
      end else begin : g_pad
        assign grp_cells[g][k] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        grp_r[g] <= grp_cells[g][lo];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi_r <= idx_ext[SEL_W-1:LO_W];
    end
  end

  assign pick = grp_r[hi_r];

endmodule
`default_nettype wire

[hw/rtl/positional_array_list.sv]
`default_nettype none
// Ordered list of up to DEPTH handles held in a chain of cells, one handle
// per cell. Each request (insert or remove at head, tail or a position)
// shifts every cell at or beyond its index by one place at once, so a new
// request is taken every cycle unless stalled. The result passes a stage
// register, then the output register; the removed handle is read out via
// a two-level select (groups of 16 cells, then the group), registered in
// between. A rejected request leaves the list as it was, noted in status.
module positional_array_list #(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pal_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pal_pkg::out_item_t      out_data
);
  import pal_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;

  logic [CMP_W-1:0] cnt_ext, pos_ext, eff_pos;
  logic             is_ins, is_rem, ins_ok, rem_ok;
  logic [1:0]       status;
  cell_op_t         op;
  logic [IDX_W-1:0] cell_idx;
  logic [ENTRY_WIDTH-1:0] new_val;
  logic [ENTRY_WIDTH+VAL_W-1:0] val_wide;

  logic [ENTRY_WIDTH-1:0] vals [DEPTH];
  logic [ENTRY_WIDTH-1:0] pick;

  logic             s1_vld_r, s1_vld_nxt;
  logic [1:0]       s1_status_r;
  logic             s1_rem_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             out_load;
  logic [ENTRY_WIDTH+VAL_W-1:0] pick_wide;
  logic [CNT_W+COUNT_W-1:0]     cnt_wide;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_vld_r && !out_load;
  assign accept   = in_valid && !in_stall;

  assign cnt_ext  = CMP_W'(count_r);
  assign pos_ext  = CMP_W'(in_data.position);
  assign val_wide = {{ENTRY_WIDTH{1'b0}}, in_data.entry_value};
  assign new_val  = val_wide[ENTRY_WIDTH-1:0];

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    eff_pos = '0;
    unique case (in_data.req_type)
      REQ_INS_HEAD: begin
        is_ins = 1'b1;
      end
      REQ_INS_TAIL: begin
        is_ins  = 1'b1;
        eff_pos = cnt_ext;
      end
      REQ_INS_POS: begin
        is_ins  = 1'b1;
        eff_pos = pos_ext;
      end
      REQ_REM_HEAD: begin
        is_rem = 1'b1;
      end
      REQ_REM_TAIL: begin
        is_rem  = 1'b1;
        eff_pos = cnt_ext - CMP_W'(1);   // wraps high on an empty list
      end
      REQ_REM_POS: begin
        is_rem  = 1'b1;
        eff_pos = pos_ext;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ins_ok    = is_ins && (cnt_ext < DEPTH_C) && (eff_pos <= cnt_ext);
    rem_ok    = is_rem && (cnt_ext != '0) && (eff_pos < cnt_ext);
    status    = ST_DONE;
    count_nxt = count_r;
    if (is_ins && !ins_ok) begin
      status = ST_INS_REJ;
    end else if (is_rem && !rem_ok) begin
      status = ST_REM_REJ;
    end
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign op.ins   = ins_ok;
  assign op.rem   = rem_ok;
  assign cell_idx = eff_pos[IDX_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = new_val;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    pal_cell #(
      .W     (ENTRY_WIDTH),
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .op        (op),
      .idx       (cell_idx),
      .left_val  (left_v),
      .right_val (right_v),
      .new_val   (new_val),
      .val       (vals[i])
    );
  end

  // samples the cells before the shift lands
  pal_sel #(
    .W     (ENTRY_WIDTH),
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_sel (
    .clk   (clk),
    .load  (accept),
    .idx   (cell_idx),
    .cells (vals),
    .pick  (pick)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (out_load) begin
      s1_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? s1_vld_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= accept ? count_nxt : count_r;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_rem_r    <= rem_ok;
      s1_cnt_r    <= count_nxt;
    end
  end

  assign pick_wide = {{VAL_W{1'b0}}, (s1_rem_r ? pick : {ENTRY_WIDTH{1'b0}})};
  assign cnt_wide  = {{COUNT_W{1'b0}}, s1_cnt_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.status        <= s1_status_r;
      out_data_r.removed_value <= pick_wide[VAL_W-1:0];
      out_data_r.entry_count   <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
